[hdl/bsyy_pkg.sv]
// Package: shared constants and types for the YUYV stitching scaler.
package bsyy_pkg;

  localparam int unsigned MaxSourceWords  = 262144;
  localparam int unsigned MaxTargetWidth  = 2048;
  localparam int unsigned MaxTargetHeight = 1024;

  localparam logic [7:0]  LaneMask = 8'hff;
  localparam logic [15:0] HiMask   = 16'hFF00;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEmit = 1'b1;

  localparam logic [1:0] RegSw = 2'd0;
  localparam logic [1:0] RegSh = 2'd1;
  localparam logic [1:0] RegTw = 2'd2;
  localparam logic [1:0] RegTh = 2'd3;

  // Effective geometry and position.
  typedef struct packed {
    logic [9:0]  wpr;
    logic [9:0]  sh;
    logic [31:0] xpos;
    logic [31:0] ypos;
  } geom_t;

endpackage

[hdl/bilinear_scale_yuyv_to_yuv420_stitch_unit.sv]
// Top level: YUYV frame store and sequenced bilinear stitching scaler.
// A load item writes one in-range source word into the frame store. An emit
// item runs two ratio divisions on one shared divider, the position multiplies
// and weight products, one address step, eight frame store reads on the one
// read port, 32 lane terms on one shared 8x33 multiply-accumulate unit, and
// a final step that writes back the last lane and loads the output register.
// Results sit in an output register; the block accepts nothing while an emit
// is in progress or a result waits.
module bilinear_scale_yuyv_to_yuv420_stitch_unit #(
  parameter int unsigned MAX_SOURCE_WORDS  = bsyy_pkg::MaxSourceWords,
  parameter int unsigned MAX_TARGET_WIDTH  = bsyy_pkg::MaxTargetWidth,
  parameter int unsigned MAX_TARGET_HEIGHT = bsyy_pkg::MaxTargetHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic        image_select_i,
  input  logic [17:0] load_address_i,
  input  logic [31:0] source_word_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] luma_left_o,
  output logic [15:0] luma_right_o,
  output logic [7:0]  chroma_u_left_o,
  output logic [7:0]  chroma_v_left_o,
  output logic [7:0]  chroma_u_right_o,
  output logic [7:0]  chroma_v_right_o,
  output logic        chroma_valid_o,
  output logic [9:0]  out_row_index_o,
  output logic [8:0]  out_column_index_o,
  output logic        frame_done_o
);
  localparam int unsigned AW = (MAX_SOURCE_WORDS > 262144) ? 18 :
                               (MAX_SOURCE_WORDS > 1) ? $clog2(MAX_SOURCE_WORDS) : 1;
  localparam int unsigned TWMAX = (MAX_TARGET_WIDTH < 2048) ? MAX_TARGET_WIDTH : 2048;
  localparam int unsigned THMAX = (MAX_TARGET_HEIGHT < 1024) ? MAX_TARGET_HEIGHT : 1024;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIVX = 9'b000000010,
    S_DIVY = 9'b000000100,
    S_MULX = 9'b000001000,
    S_MULY = 9'b000010000,
    S_ADDR = 9'b000100000,
    S_READ = 9'b001000000,
    S_MAC  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] sw_reg_q;
  logic [9:0]  sh_reg_q;
  logic [11:0] tw_reg_q;
  logic [10:0] th_reg_q;

  logic [31:0] mem [2**(AW+1)];

  logic [10:0] sw;
  logic [9:0]  sh;
  logic [11:0] tw;
  logic [10:0] th;
  logic [9:0]  wpr;
  logic [9:0]  cols;
  logic [9:0]  row_cnt_q, row_cnt_d;
  logic [8:0]  col_cnt_q, col_cnt_d;
  logic [9:0]  row_c;
  logic [9:0]  col_c;

  logic        div_start, div_done;
  logic [25:0] div_num, div_quo;
  logic [11:0] div_den;
  logic [25:0] xratio_q, yratio_q;
  logic [31:0] xpos_q, ypos_q;

  logic [15:0] fx, fy;
  logic [15:0] xw, ys;
  logic [9:0]  x0, xr, y0, y1;
  logic [32:0] wts [4];
  logic [16:0] ia, ib;

  logic [19:0] base0_q, base1_q;
  logic [2:0]  rd_idx_q;
  logic        rd_vld_q;
  logic [2:0]  rd_tag_q;
  logic [31:0] rd_data_q;
  logic [31:0] words_q [8];
  logic [20:0] rd_lin;
  logic [31:0] rd_word;
  logic        rd_oor;
  logic        rd_oor_q;

  logic [4:0]  mac_idx_q;
  logic [1:0]  m_term;
  logic [1:0]  m_lane;
  logic        m_frame;
  logic [7:0]  mac_pix;
  logic [7:0]  mac_res;
  logic        mac_clr, mac_en;
  logic [31:0] res_q [2];

  logic        accept_in, accept_out;

  assign sw = ((sw_reg_q < 11'd2) ? 11'd2 : (sw_reg_q > 11'd1024) ? 11'd1024 : sw_reg_q)
              & 11'h7fe;
  assign sh = (sh_reg_q < 10'd2) ? 10'd2 : (sh_reg_q > 10'd512) ? 10'd512 : sh_reg_q;
  assign tw = ((tw_reg_q < 12'd8) ? 12'd8 :
               (tw_reg_q > 12'(TWMAX)) ? 12'(TWMAX) : tw_reg_q) & 12'hff8;
  assign th = (th_reg_q < 11'd2) ? 11'd2 :
              (th_reg_q > 11'(THMAX)) ? 11'(THMAX) : th_reg_q;
  assign wpr  = sw[10:1];
  assign cols = tw[11:2];
  assign row_c = ({1'b0, row_cnt_q} >= th) ? 10'd0 : row_cnt_q;
  assign col_c = ({1'b0, col_cnt_q} >= cols) ? 10'd0 : {1'b0, col_cnt_q};

  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_o;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign accept_out  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_reg_q <= 11'd640;
      sh_reg_q <= 10'd480;
      tw_reg_q <= 12'd1280;
      th_reg_q <= 11'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bsyy_pkg::RegSw: sw_reg_q <= cfg_data_i[10:0];
        bsyy_pkg::RegSh: sh_reg_q <= cfg_data_i[9:0];
        bsyy_pkg::RegTw: tw_reg_q <= cfg_data_i;
        bsyy_pkg::RegTh: th_reg_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign div_start = (state_q == S_IDLE && accept_in && opcode_i == bsyy_pkg::OpEmit) ||
                     (state_q == S_DIVX && div_done);
  assign div_num = (state_q == S_IDLE) ? {5'd0, sw - 11'd1, 10'd0} << 6
                                       : {6'd0, sh - 10'd1, 10'd0} << 6;
  assign div_den = (state_q == S_IDLE) ? {1'b0, tw[11:1]} : {1'b0, th};

  bsyy_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign fx = xpos_q[15:0];
  assign fy = ypos_q[15:0];
  assign xw = xpos_q[31:16];
  assign ys = ypos_q[31:16];
  assign x0 = (xw > {6'd0, wpr - 10'd1}) ? wpr - 10'd1 : xw[9:0];
  assign xr = (x0 + 10'd1 > wpr - 10'd1) ? wpr - 10'd1 : x0 + 10'd1;
  assign y0 = (ys > {6'd0, sh - 10'd1}) ? sh - 10'd1 : ys[9:0];
  assign y1 = (y0 + 10'd1 > sh - 10'd1) ? sh - 10'd1 : y0 + 10'd1;

  assign ia = 17'd65536 - {1'b0, fx};
  assign ib = 17'd65536 - {1'b0, fy};

  always_ff @(posedge clk_i) begin
    if (state_q == S_MULY) begin
      wts[0] <= 33'(ia * ib);
      wts[1] <= 33'({1'b0, fx} * ib);
      wts[2] <= 33'(ia * {1'b0, fy});
      wts[3] <= 33'({1'b0, fx} * {1'b0, fy});
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIVX && div_done) xratio_q <= div_quo;
    if (state_q == S_DIVY && div_done) yratio_q <= div_quo;
    if (state_q == S_DIVY && div_done) xpos_q <= 32'(xratio_q * col_c);
    if (state_q == S_MULX) ypos_q <= 32'(yratio_q * row_c);
    if (state_q == S_MULY) begin
      base0_q <= 20'(y0 * wpr);
      base1_q <= 20'(y1 * wpr);
    end
  end

  assign rd_lin = rd_idx_q[1] ? (21'(base1_q) + 21'(rd_idx_q[0] ? xr : x0))
                              : (21'(base0_q) + 21'(rd_idx_q[0] ? xr : x0));
  assign rd_oor = rd_lin >= 21'(MAX_SOURCE_WORDS);

  always_ff @(posedge clk_i) begin
    if (accept_in && opcode_i == bsyy_pkg::OpLoad &&
        {3'd0, load_address_i} < 21'(MAX_SOURCE_WORDS)) begin
      mem[{image_select_i, load_address_i[AW-1:0]}] <= source_word_i;
    end
    rd_data_q <= mem[{rd_idx_q[2], rd_lin[AW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_READ);
    end
  end

  assign rd_word = rd_data_q;

  always_ff @(posedge clk_i) begin
    rd_tag_q <= rd_idx_q;
    if (state_q == S_READ) rd_oor_q <= rd_oor;
    if (rd_vld_q) words_q[rd_tag_q] <= rd_oor_q ? 32'd0 : rd_word;
  end

  assign m_term  = mac_idx_q[1:0];
  assign m_lane  = mac_idx_q[3:2];
  assign m_frame = mac_idx_q[4];
  assign mac_pix = 8'(words_q[{m_frame, m_term}] >> {m_lane, 3'd0}) & bsyy_pkg::LaneMask;
  assign mac_en  = (state_q == S_MAC);
  assign mac_clr = (m_term == 2'd0);

  logic [32:0] mac_w;
  assign mac_w = wts[m_term];

  bsyy_mac u_mac (
    .clk_i (clk_i),
    .clr_i (mac_clr),
    .en_i  (mac_en),
    .pix_i (mac_pix),
    .wgt_i (mac_w),
    .res_o (mac_res)
  );

  logic        lane_wr_q;
  logic [4:0]  lane_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_wr_q <= 1'b0;
    end else begin
      lane_wr_q <= mac_en && (m_term == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    lane_idx_q <= mac_idx_q;
    if (lane_wr_q) begin
      res_q[lane_idx_q[4]][{lane_idx_q[3:2], 3'd0} +: 8] <= mac_res;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept_in && opcode_i == bsyy_pkg::OpEmit) state_d = S_DIVX;
      S_DIVX: if (div_done) state_d = S_DIVY;
      S_DIVY: if (div_done) state_d = S_MULX;
      S_MULX: state_d = S_MULY;
      S_MULY: state_d = S_ADDR;
      S_ADDR: state_d = S_READ;
      S_READ: if (rd_idx_q == 3'd7) state_d = S_MAC;
      S_MAC:  if (mac_idx_q == 5'd31) state_d = S_DONE;
      S_DONE: if (!lane_wr_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic last_col, last_row;
  assign last_col = (col_c + 10'd1 >= cols);
  assign last_row = ({1'b0, row_c} + 11'd1 >= th);
  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (state_q == S_DONE && !lane_wr_q) begin
      if (last_col) begin
        col_cnt_d = '0;
        row_cnt_d = last_row ? 10'd0 : row_c + 10'd1;
      end else begin
        col_cnt_d = 9'(col_c + 10'd1);
      end
    end
  end

  logic out_valid_q;
  logic chroma_en;
  assign chroma_en = !row_c[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      rd_idx_q    <= '0;
      mac_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      rd_idx_q  <= (state_q == S_READ) ? rd_idx_q + 3'd1 : 3'd0;
      mac_idx_q <= (state_q == S_MAC) ? mac_idx_q + 5'd1 : 5'd0;
      if (state_q == S_DONE && !lane_wr_q) out_valid_q <= 1'b1;
      else if (accept_out) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && !lane_wr_q) begin
      luma_left_o        <= {res_q[0][23:16], res_q[0][7:0]};
      luma_right_o       <= {res_q[1][23:16], res_q[1][7:0]};
      chroma_u_left_o    <= chroma_en ? res_q[0][15:8] : 8'd0;
      chroma_v_left_o    <= chroma_en ? res_q[0][31:24] : 8'd0;
      chroma_u_right_o   <= chroma_en ? res_q[1][15:8] : 8'd0;
      chroma_v_right_o   <= chroma_en ? res_q[1][31:24] : 8'd0;
      chroma_valid_o     <= chroma_en;
      out_row_index_o    <= row_c;
      out_column_index_o <= col_c[8:0];
      frame_done_o       <= last_col && ({1'b0, row_c} + 11'd1 == th) &&
                            (col_c + 10'd1 == cols);
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

[hdl/bsyy_div.sv]
// Module: restoring divider, one quotient bit per cycle.
module bsyy_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [25:0] num_i,
  input  logic [11:0] den_i,
  output logic        done_o,
  output logic [25:0] quo_o
);
  logic [25:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [12:0] trial;

  assign trial  = {rem_q[11:0], quo_q[25]};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == 5'd0);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 5'd26;
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != 5'd0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[24:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[24:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule

[hdl/bsyy_mac.sv]
// Module: shared 8x33 multiply-accumulate unit for one lane term per cycle while enabled.
module bsyy_mac (
  input  logic        clk_i,
  input  logic        clr_i,
  input  logic        en_i,
  input  logic [7:0]  pix_i,
  input  logic [32:0] wgt_i,
  output logic [7:0]  res_o
);
  logic [40:0] acc_q, acc_d;
  logic [40:0] prod;

  assign prod  = {33'd0, pix_i} * {8'd0, wgt_i};
  assign res_o = acc_q[39:32];

  // Start a new sum with the first term of a lane.
  always_comb begin
    acc_d = acc_q;
    if (en_i) acc_d = (clr_i ? 41'd0 : acc_q) + prod;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end
endmodule
